// ----- rtl/mcec_pkg.sv -----
// Shared types and codes for the multi-car elevator controller.
package mcec_pkg;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_UP   = 2'd0;
	localparam mode_t MODE_DOWN = 2'd1;
	localparam mode_t MODE_IDLE = 2'd2;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_REQ  = 1'b1;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status of one car step, unit to sequencer.
	typedef struct packed {
		logic  door;
		mode_t mode;
	} car_stat_t;

endpackage

// ----- rtl/mcec_if.sv -----
// Request and result channel interfaces.
interface mcec_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [3:0] floor;

	modport source (output valid, output action, output floor, input ready);
	modport sink   (input valid, input action, input floor, output ready);
endinterface

interface mcec_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [2:0] car;
	logic [3:0] car_floor;
	logic [1:0] motion;
	logic       door_opened;
	logic       last;

	modport source (output valid, output kind, output car, output car_floor,
		output motion, output door_opened, output last, input ready);
	modport sink   (input valid, input kind, input car, input car_floor,
		input motion, input door_opened, input last, output ready);
endinterface

// ----- rtl/mcec_car_unit.sv -----
// Shared car step unit: distance, request apply and one tick for one car.
module mcec_car_unit #(
	parameter int NUM_FLOORS = 16
) (
	input  logic                          tick,
	input  logic [$clog2(NUM_FLOORS)-1:0] floor,
	input  logic [$clog2(NUM_FLOORS)-1:0] pos,
	input  mcec_pkg::mode_t               mode,
	input  logic [NUM_FLOORS-1:0]         up_map,
	input  logic [NUM_FLOORS-1:0]         dn_map,
	output logic [$clog2(NUM_FLOORS)-1:0] gap,
	output logic [$clog2(NUM_FLOORS)-1:0] pos_nxt,
	output logic [NUM_FLOORS-1:0]         up_nxt,
	output logic [NUM_FLOORS-1:0]         dn_nxt,
	output mcec_pkg::car_stat_t           stat
);
	localparam int FW = $clog2(NUM_FLOORS);

	logic [NUM_FLOORS-1:0] here;
	logic [NUM_FLOORS-1:0] below;
	logic [NUM_FLOORS-1:0] above;
	logic [NUM_FLOORS-1:0] req_bit;
	logic                  up_hit;
	logic                  dn_hit;
	logic                  at_top;
	logic                  at_bot;
	logic                  f_above;
	logic                  f_below;

	assign here    = NUM_FLOORS'(1) << pos;
	assign below   = here - NUM_FLOORS'(1);
	assign above   = ~(here | below);
	assign req_bit = NUM_FLOORS'(1) << floor;

	// this floor is the lowest up stop (up) or the highest down stop (down)
	assign up_hit = up_map[pos] & ~|(up_map & below);
	assign dn_hit = dn_map[pos] & ~|(dn_map & above);
	assign at_top = (pos == FW'(NUM_FLOORS - 1));
	assign at_bot = (pos == '0);

	assign f_above = floor > pos;
	assign f_below = floor < pos;
	assign gap     = f_above ? (floor - pos) : (pos - floor);

	always_comb begin
		pos_nxt   = pos;
		up_nxt    = up_map;
		dn_nxt    = dn_map;
		stat.door = 1'b0;
		stat.mode = mode;
		if (!tick) begin
			if (f_above) begin
				up_nxt = up_map | req_bit;
			end else if (f_below) begin
				dn_nxt = dn_map | req_bit;
			end else begin
				stat.door = 1'b1;
			end
		end else begin
			unique case (mode)
				mcec_pkg::MODE_UP: begin
					if (up_map == '0) begin
						stat.mode = mcec_pkg::MODE_IDLE;
					end else if (up_hit) begin
						up_nxt    = up_map & ~here;
						stat.door = 1'b1;
					end else if (!at_top) begin
						pos_nxt = pos + FW'(1);
					end
				end
				mcec_pkg::MODE_DOWN: begin
					if (dn_map == '0) begin
						stat.mode = mcec_pkg::MODE_IDLE;
					end else if (dn_hit) begin
						dn_nxt    = dn_map & ~here;
						stat.door = 1'b1;
					end else if (!at_bot) begin
						pos_nxt = pos - FW'(1);
					end
				end
				default: begin
					if (up_map != '0) begin
						stat.mode = mcec_pkg::MODE_UP;
						if (!at_top) pos_nxt = pos + FW'(1);
					end else if (dn_map != '0) begin
						stat.mode = mcec_pkg::MODE_DOWN;
						if (!at_bot) pos_nxt = pos - FW'(1);
					end else begin
						stat.mode = mcec_pkg::MODE_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/multi_car_elevator_controller.sv -----
// Multi-car elevator controller: sequencer, car state and result register.
//
// Usage: requests come in on req (action, floor), results leave on res.
// action = 1 is a floor request: the cars are scanned one per cycle for the
// one nearest to the floor (lowest index wins a tie), then the apply step
// writes the stop to that car and loads a single assignment result (last = 1).
// action = 0 is a time tick: each car in index order is stepped, one car per
// cycle while res is not stalled, and gives one status result; the last car's
// result has last = 1. The one shared car step unit handles one car
// per cycle. req.ready is high only between items, so a new item is not
// taken before the block is through with the last one.
// Floors at or above NUM_FLOORS are taken as the top floor.
// Results sit in an output register; while it is full and res.ready is low
// the apply and tick steps hold their place and lose nothing, and req stays
// blocked until the item's last result has been loaded.
// Reset (arst_n low) puts all cars idle at floor 0 with no stops and
// empties the result register.
module multi_car_elevator_controller #(
	parameter int NUM_CARS   = 2,
	parameter int NUM_FLOORS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mcec_req_if.sink     req,
	mcec_res_if.source   res
);
	localparam int FW = $clog2(NUM_FLOORS);
	localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_TICK  = 2'd3;

	logic [1:0]            state_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         best_q;
	logic [FW-1:0]         bestd_q;
	logic [FW-1:0]         floor_q;

	// per-car state
	logic [NUM_FLOORS-1:0] up_q   [NUM_CARS];
	logic [NUM_FLOORS-1:0] dn_q   [NUM_CARS];
	logic [FW-1:0]         pos_q  [NUM_CARS];
	mcec_pkg::mode_t       mode_q [NUM_CARS];

	// result register
	logic                  ov_q;
	logic                  okind_q;
	logic [2:0]            ocar_q;
	logic [3:0]            ofloor_q;
	logic [1:0]            omotion_q;
	logic                  odoor_q;
	logic                  olast_q;

	logic [CW-1:0]         sel;
	logic [FW-1:0]         gap;
	logic [FW-1:0]         pos_nxt;
	logic [NUM_FLOORS-1:0] up_nxt;
	logic [NUM_FLOORS-1:0] dn_nxt;
	mcec_pkg::car_stat_t   stat;
	logic                  ofree;
	logic                  last_car;
	logic [6:0]            f_wide;
	logic [FW-1:0]         f_clamp;
	logic                  commit;

	assign sel      = (state_q == S_APPLY) ? best_q : idx_q;
	assign ofree    = !ov_q || res.ready;
	assign last_car = (idx_q == CW'(NUM_CARS - 1));
	assign commit   = ofree && (state_q == S_APPLY || state_q == S_TICK);

	assign f_wide  = 7'(req.floor);
	assign f_clamp = (f_wide >= 7'(NUM_FLOORS)) ? FW'(NUM_FLOORS - 1) : FW'(req.floor);

	assign req.ready = (state_q == S_IDLE);

	mcec_car_unit #(
		.NUM_FLOORS(NUM_FLOORS)
	) u_unit (
		.tick    (state_q == S_TICK),
		.floor   (floor_q),
		.pos     (pos_q[sel]),
		.mode    (mode_q[sel]),
		.up_map  (up_q[sel]),
		.dn_map  (dn_q[sel]),
		.gap     (gap),
		.pos_nxt (pos_nxt),
		.up_nxt  (up_nxt),
		.dn_nxt  (dn_nxt),
		.stat    (stat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			best_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q <= '0;
						state_q <= (req.action == mcec_pkg::ACT_REQ) ? S_SCAN : S_TICK;
					end
				end
				S_SCAN: begin
					if (idx_q == '0 || gap < bestd_q) best_q <= idx_q;
					if (last_car) state_q <= S_APPLY;
					else idx_q <= idx_q + CW'(1);
				end
				S_APPLY: begin
					if (ofree) state_q <= S_IDLE;
				end
				default: begin
					if (ofree) begin
						if (last_car) state_q <= S_IDLE;
						else idx_q <= idx_q + CW'(1);
					end
				end
			endcase
		end
	end

	// request floor and best distance so far
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) floor_q <= f_clamp;
		if (state_q == S_SCAN && (idx_q == '0 || gap < bestd_q)) bestd_q <= gap;
	end

	// car state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CARS; i++) begin
				up_q[i]   <= '0;
				dn_q[i]   <= '0;
				pos_q[i]  <= '0;
				mode_q[i] <= mcec_pkg::MODE_IDLE;
			end
		end else if (commit) begin
			up_q[sel]   <= up_nxt;
			dn_q[sel]   <= dn_nxt;
			pos_q[sel]  <= pos_nxt;
			mode_q[sel] <= stat.mode;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (commit) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (commit) begin
			okind_q   <= (state_q == S_TICK) ? mcec_pkg::KIND_STATUS : mcec_pkg::KIND_ASSIGN;
			ocar_q    <= 3'(sel);
			ofloor_q  <= 4'(pos_nxt);
			omotion_q <= stat.mode;
			odoor_q   <= stat.door;
			olast_q   <= (state_q == S_APPLY) || last_car;
		end
	end

	assign res.valid       = ov_q;
	assign res.kind        = okind_q;
	assign res.car         = ocar_q;
	assign res.car_floor   = ofloor_q;
	assign res.motion      = omotion_q;
	assign res.door_opened = odoor_q;
	assign res.last        = olast_q;

endmodule

// ----- sim/mcec_checker.sv -----
// Prediction and result comparison for the elevator controller.
module mcec_checker #(
	parameter int NUM_CARS   = 2,
	parameter int NUM_FLOORS = 16
) (
	input  logic clk,
	input  logic arst_n,
	mcec_req_if  req,
	mcec_res_if  res,
	output int   errors,
	output int   pending
);
	typedef struct packed {
		logic            kind;
		logic [2:0]      car;
		logic [3:0]      car_floor;
		mcec_pkg::mode_t motion;
		logic            door_opened;
		logic            last;
	} car_report_t;

	logic [63:0]     up_stops   [NUM_CARS];
	logic [63:0]     down_stops [NUM_CARS];
	int              car_at     [NUM_CARS];
	mcec_pkg::mode_t heading    [NUM_CARS];
	car_report_t     reports_due[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	// one floor in the current heading, clamped at the shaft ends
	function automatic void move_car(int c);
		if (heading[c] == mcec_pkg::MODE_UP) begin
			if (car_at[c] + 1 < NUM_FLOORS)
				car_at[c]++;
		end else if (heading[c] == mcec_pkg::MODE_DOWN) begin
			if (car_at[c] > 0)
				car_at[c]--;
		end
	endfunction

	// one tick of one car; returns 1 when a stop was served
	function automatic logic step_car(int c);
		logic [63:0] stops;
		int          target;
		if (heading[c] == mcec_pkg::MODE_UP || heading[c] == mcec_pkg::MODE_DOWN) begin
			stops = (heading[c] == mcec_pkg::MODE_UP) ? up_stops[c] : down_stops[c];
			if (stops == '0) begin
				heading[c] = mcec_pkg::MODE_IDLE;
				return 1'b0;
			end
			if (heading[c] == mcec_pkg::MODE_UP) begin
				target = 0;
				while (target < 63 && !stops[target])
					target++;
			end else begin
				target = 63;
				while (target > 0 && !stops[target])
					target--;
			end
			if (target == car_at[c]) begin
				if (heading[c] == mcec_pkg::MODE_UP)
					up_stops[c][target] = 1'b0;
				else
					down_stops[c][target] = 1'b0;
				return 1'b1;
			end
			move_car(c);
			return 1'b0;
		end
		if (up_stops[c] != '0) begin
			heading[c] = mcec_pkg::MODE_UP;
			move_car(c);
		end else if (down_stops[c] != '0) begin
			heading[c] = mcec_pkg::MODE_DOWN;
			move_car(c);
		end else begin
			heading[c] = mcec_pkg::MODE_IDLE;
		end
		return 1'b0;
	endfunction

	function automatic void predict_dispatch(logic act, logic [3:0] fl);
		int   target;
		int   best;
		int   best_dist;
		int   span;
		logic door;
		if (act == mcec_pkg::ACT_REQ) begin
			target    = (int'(fl) >= NUM_FLOORS) ? NUM_FLOORS - 1 : int'(fl);
			best      = 0;
			best_dist = 1000;
			for (int c = 0; c < NUM_CARS; c++) begin
				span = (car_at[c] > target) ? car_at[c] - target : target - car_at[c];
				if (span < best_dist) begin
					best_dist = span;
					best      = c;
				end
			end
			door = 1'b0;
			if (target > car_at[best])
				up_stops[best][target] = 1'b1;
			else if (target < car_at[best])
				down_stops[best][target] = 1'b1;
			else
				door = 1'b1;
			reports_due.push_back(car_report_t'{mcec_pkg::KIND_ASSIGN, best[2:0],
				car_at[best][3:0], heading[best], door, 1'b1});
		end else begin
			for (int c = 0; c < NUM_CARS; c++) begin
				door = step_car(c);
				reports_due.push_back(car_report_t'{mcec_pkg::KIND_STATUS, c[2:0],
					car_at[c][3:0], heading[c], door, logic'(c == NUM_CARS - 1)});
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		car_report_t got;
		car_report_t want;
		if (!arst_n) begin
			for (int c = 0; c < NUM_CARS; c++) begin
				up_stops[c]   = '0;
				down_stops[c] = '0;
				car_at[c]     = 0;
				heading[c]    = mcec_pkg::MODE_IDLE;
			end
			reports_due.delete();
			errors = 0;
		end else begin
			if (req.valid && req.ready)
				predict_dispatch(req.action, req.floor);
			if (res.valid && res.ready) begin
				got = car_report_t'{res.kind, res.car, res.car_floor, res.motion,
					res.door_opened, res.last};
				if (reports_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display({"unexpected result: kind %0d car %0d floor %0d",
							" motion %0d door %0d last %0d"},
							got.kind, got.car, got.car_floor, got.motion,
							got.door_opened, got.last);
				end else begin
					want = reports_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: kind %0d/%0d car %0d/%0d floor %0d/%0d",
								" motion %0d/%0d door %0d/%0d last %0d/%0d (exp/act)"},
								want.kind, got.kind, want.car, got.car,
								want.car_floor, got.car_floor, want.motion, got.motion,
								want.door_opened, got.door_opened, want.last, got.last);
					end
				end
			end
		end
		pending = reports_due.size();
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top: stimulus, handshake pacing and verdict for the elevator controller.
module tb;
	localparam int NUM_CARS    = 2;
	localparam int NUM_FLOORS  = 16;
	localparam int RANDOM_REQS = 220;
	// receiver blackout, long enough to back results up into the request side
	localparam int HOLD_CYCLES = 300;
	// drain margin, well past the length of one tick or request
	localparam int DRAIN       = 20;
	// roughly 250 items, a few stalled results each, plus the blackout, many times over
	localparam int CYCLE_LIMIT = 100000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycle_count;

	// pacing knobs set by the stimulus; sink_steady and hold_off_go also steer the receiver
	bit   sender_idles;
	bit   sink_steady;
	bit   hold_off_go;

	mcec_req_if req_ch ();
	mcec_res_if res_ch ();

	multi_car_elevator_controller #(
		.NUM_CARS   (NUM_CARS),
		.NUM_FLOORS (NUM_FLOORS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	mcec_checker #(
		.NUM_CARS   (NUM_CARS),
		.NUM_FLOORS (NUM_FLOORS)
	) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one request and hold it until the block takes it. Ready is sampled
	// on the falling edge, so the decision never races the block's own update
	// at the rising edge. Valid stays high straight into the next request when
	// no idle gap is drawn, so it is never dropped and raised in one step.
	task automatic send_request(input logic act, input logic [3:0] fl);
		logic took;
		if (sender_idles) begin
			while ($urandom_range(0, 99) < 20) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.floor  <= fl;
		do begin
			@(negedge clk);
			took = req_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Receiver: random stalls about one cycle in five, a steady stretch while
	// sink_steady is set, and one long blackout counted here when asked for.
	initial begin
		int stall_left;
		stall_left   = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_off_go) begin
				hold_off_go  = 1'b0;
				stall_left   = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic       act;
		logic [3:0] fl;
		sender_idles  = 1'b0;
		sink_steady   = 1'b1;
		hold_off_go   = 1'b0;
		arst_n        = 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.action <= mcec_pkg::ACT_TICK;
		req_ch.floor  <= 4'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk. Both cars start idle at the ground floor.
		send_request(mcec_pkg::ACT_TICK, 4'd0);   // nothing pending: both stay idle
		send_request(mcec_pkg::ACT_REQ, 4'd0);    // car 0 already there: door opens
		send_request(mcec_pkg::ACT_REQ, 4'd15);   // top floor goes into car 0's up stops
		send_request(mcec_pkg::ACT_REQ, 4'd0);    // tie on distance, lowest index wins
		send_request(mcec_pkg::ACT_TICK, 4'hF);   // car 0 starts up and moves in the same tick
		send_request(mcec_pkg::ACT_TICK, 4'hA);
		send_request(mcec_pkg::ACT_TICK, 4'h5);   // car 0 now on floor 3
		send_request(mcec_pkg::ACT_REQ, 4'd0);    // car 1 nearer now: door at ground
		send_request(mcec_pkg::ACT_REQ, 4'd1);    // car 1 gets an up stop
		send_request(mcec_pkg::ACT_REQ, 4'd2);    // car 0 gets a down stop behind it
		send_request(mcec_pkg::ACT_REQ, 4'd15);   // repeat of a pending stop, no change
		send_request(mcec_pkg::ACT_TICK, 4'd0);   // car 1 reaches floor 1
		send_request(mcec_pkg::ACT_TICK, 4'd0);   // car 1 serves floor 1 and stays put
		send_request(mcec_pkg::ACT_TICK, 4'd0);   // car 1 runs out of up stops and idles
		send_request(mcec_pkg::ACT_REQ, 4'd9);
		send_request(mcec_pkg::ACT_REQ, 4'd8);
		repeat (9) send_request(mcec_pkg::ACT_TICK, 4'd0);

		// Random traffic: a calm opening stretch, then idling on both sides,
		// with one receiver blackout in the middle while requests keep coming.
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == 50) begin
				sender_idles = 1'b1;
				sink_steady  = 1'b0;
			end
			if (i == 120)
				hold_off_go = 1'b1;
			act = ($urandom_range(0, 99) < 50) ? mcec_pkg::ACT_REQ : mcec_pkg::ACT_TICK;
			fl  = 4'($urandom_range(0, 15));
			send_request(act, fl);
		end
		req_ch.valid <= 1'b0;

		// Let the checker see the final acceptance before reading its backlog.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
